// File: rtl/ellipse_outline_vertex_generator_top_defines.svh
// Assertion macros shared by the checker.
`ifndef ELLIPSE_OUTLINE_VERTEX_GENERATOR_TOP_DEFINES_SVH
`define ELLIPSE_OUTLINE_VERTEX_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication.
`define EOVG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eovg check failed");

// Next-cycle implication.
`define EOVG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eovg check failed");

`endif

// File: rtl/eovg_pkg.sv
package eovg_pkg;

   localparam logic [6:0] MaxSegments = 7'd64;
   localparam int unsigned CsrIndexBits = 3;
   localparam int unsigned CsrDataBits = 24;

   localparam logic [CsrIndexBits-1:0] RegCenterX = 3'd0;
   localparam logic [CsrIndexBits-1:0] RegCenterY = 3'd1;
   localparam logic [CsrIndexBits-1:0] RegRadiusX = 3'd2;
   localparam logic [CsrIndexBits-1:0] RegRadiusY = 3'd3;
   localparam logic [CsrIndexBits-1:0] RegRotation = 3'd4;

   // 2*pi in Q30
   localparam longint unsigned TwoPiQ30 = 64'd6746518852;
   localparam longint unsigned OneQ14 = 64'd16384;

   typedef struct packed {
      logic [6:0] segment_request;
      logic [6:0] room;
   } req_type;

   typedef struct packed {
      logic signed [23:0] vertex_x;
      logic signed [23:0] vertex_y;
      logic [5:0]         vertex_index;
      logic [6:0]         segment_total;
      logic               written;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] center_x;
      logic signed [23:0] center_y;
      logic [22:0]        radius_x;
      logic [22:0]        radius_y;
      logic [15:0]        rotation;
   } cfg_type;

   typedef struct packed {
      logic [6:0] total;
      logic       fits;
   } job_type;

endpackage

// File: rtl/ellipse_outline_vertex_generator_top.sv
// Rotated ellipse outline generator. Each request names a vertex count N (0 or
// anything above 64 means 64) and the receiver's room. If room < N the block
// returns one beat with written = 0 and the count only; otherwise it returns N
// vertex beats in index order, the last one flagged. Up to two requests queue
// up in front while the back end works. A vertex request is first taken, then
// its phase step is found with a one-bit-per-cycle divider, and then it issues
// one vertex per cycle, while the output is not stalled, into a five-stage
// lookup/multiply/round pipeline. The back end takes no new request until the
// last vertex of the current one has issued.
// Configuration registers may only be written while no request is in flight.
module ellipse_outline_vertex_generator_top #(
   parameter int unsigned SINE_TABLE_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  eovg_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output eovg_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [eovg_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [eovg_pkg::CsrDataBits-1:0]    csr_wr_data
);
   import eovg_pkg::*;

   cfg_type cfg_ff;
   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    job_valid;
   job_type job;
   logic    job_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            RegCenterX:  cfg_ff.center_x <= csr_wr_data;
            RegCenterY:  cfg_ff.center_y <= csr_wr_data;
            RegRadiusX:  cfg_ff.radius_x <= csr_wr_data[22:0];
            RegRadiusY:  cfg_ff.radius_y <= csr_wr_data[22:0];
            RegRotation: cfg_ff.rotation <= csr_wr_data[15:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   eovg_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   eovg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop_valid (job_valid),
      .pop_job   (job),
      .pop       (job_pop)
   );

   eovg_back #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/eovg_front.sv
module eovg_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  eovg_pkg::req_type req_data,
   input  logic              queue_full,
   output logic              push,
   output eovg_pkg::job_type job
);
   import eovg_pkg::*;

   logic [6:0] count_sat;
   logic [6:0] room_sat;

   always_comb begin
      if (req_data.segment_request == 7'd0 || req_data.segment_request > MaxSegments) begin
         count_sat = MaxSegments;
      end else begin
         count_sat = req_data.segment_request;
      end
      room_sat = (req_data.room > MaxSegments) ? MaxSegments : req_data.room;
      job.total = count_sat;
      job.fits = (room_sat >= count_sat);
   end

   assign req_stall = queue_full;
   assign push = req_valid && !queue_full;

endmodule

// File: rtl/eovg_queue.sv
module eovg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  eovg_pkg::job_type push_job,
   output logic              full,
   output logic              pop_valid,
   output eovg_pkg::job_type pop_job,
   input  logic              pop
);
   import eovg_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_job = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/eovg_back.sv
module eovg_back #(
   parameter int unsigned SINE_TABLE_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  eovg_pkg::cfg_type cfg,
   input  logic              job_valid,
   input  eovg_pkg::job_type job,
   output logic              job_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output eovg_pkg::rsp_type rsp_data
);
   import eovg_pkg::*;

   localparam int unsigned Quarter = 1 << (SINE_TABLE_BITS - 2);
   localparam int unsigned AddrBits = SINE_TABLE_BITS - 1;
   // 2^32 has 33 dividend bits
   localparam int unsigned DivSteps = 33;

   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StDivide = 2'd1;
   localparam logic [1:0] StEmit = 2'd2;

   typedef struct packed {
      logic [5:0] index;
      logic [6:0] total;
      logic       written;
      logic       last;
   } meta_type;

   logic [14:0] qtab [Quarter+1];

   for (genvar g = 0; g <= Quarter; g++) begin : g_qtab
      // Q30 Taylor series of sin at 2*pi*g/2^SINE_TABLE_BITS, rounded to Q1.14
      localparam longint unsigned AngleQ30 =
         (TwoPiQ30 * 64'(g) + (64'd1 << (SINE_TABLE_BITS - 1))) >> SINE_TABLE_BITS;
      localparam longint unsigned AngleSqQ30 = (AngleQ30 * AngleQ30 + (64'd1 << 29)) >> 30;
      localparam longint unsigned Term1 = ((AngleQ30 * AngleSqQ30) >> 30) / 64'd6;
      localparam longint unsigned Term2 = ((Term1 * AngleSqQ30) >> 30) / 64'd20;
      localparam longint unsigned Term3 = ((Term2 * AngleSqQ30) >> 30) / 64'd42;
      localparam longint unsigned Term4 = ((Term3 * AngleSqQ30) >> 30) / 64'd72;
      localparam longint unsigned Term5 = ((Term4 * AngleSqQ30) >> 30) / 64'd110;
      localparam longint unsigned Term6 = ((Term5 * AngleSqQ30) >> 30) / 64'd156;
      localparam longint unsigned Term7 = ((Term6 * AngleSqQ30) >> 30) / 64'd210;
      localparam longint unsigned Term8 = ((Term7 * AngleSqQ30) >> 30) / 64'd272;
      localparam longint unsigned Term9 = ((Term8 * AngleSqQ30) >> 30) / 64'd342;
      localparam longint unsigned Term10 = ((Term9 * AngleSqQ30) >> 30) / 64'd420;
      localparam longint SumQ30 = longint'(AngleQ30) - longint'(Term1) + longint'(Term2)
         - longint'(Term3) + longint'(Term4) - longint'(Term5) + longint'(Term6)
         - longint'(Term7) + longint'(Term8) - longint'(Term9) + longint'(Term10);
      localparam longint unsigned Rounded =
         (SumQ30 <= 64'sd0) ? 64'd0 : (($unsigned(SumQ30) + 64'd32768) >> 16);
      localparam logic [14:0] Entry = (Rounded > OneQ14) ? 15'(OneQ14) : 15'(Rounded);
      assign qtab[g] = Entry;
   end

   function automatic logic signed [15:0] sine_lookup(input logic [15:0] angle);
      logic [SINE_TABLE_BITS-1:0] k;
      logic [AddrBits-1:0]        j;
      logic [AddrBits-1:0]        addr;
      logic [15:0]                mag;
      k = angle[15 -: SINE_TABLE_BITS];
      j = {1'b0, k[SINE_TABLE_BITS-3:0]};
      addr = k[SINE_TABLE_BITS-2] ? (AddrBits'(Quarter) - j) : j;
      mag = {1'b0, qtab[addr]};
      return k[SINE_TABLE_BITS-1] ? -$signed(mag) : $signed(mag);
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
      if (v > 27'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (v < -27'sd8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

   // Sequencer and step divider
   logic [1:0]         state_ff, state_in;
   logic [5:0]         div_cnt_ff, div_cnt_in;
   logic [6:0]         rem_ff, rem_in;
   logic [31:0]        quo_ff, quo_in;
   logic [31:0]        acc_ff, acc_in;
   logic [5:0]         idx_ff, idx_in;
   logic [6:0]         total_ff, total_in;
   logic signed [15:0] ca_ff, ca_in;
   logic signed [15:0] sa_ff, sa_in;
   logic               adv;
   logic               issue;
   meta_type           issue_meta;
   logic [7:0]         rem_shift;
   logic               rem_ge;
   logic [6:0]         rem_sub;
   logic               last_vertex;

   // Vertex pipeline
   logic               a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, rsp_valid_ff;
   meta_type           a_meta_ff, b_meta_ff, c_meta_ff, d_meta_ff;
   logic signed [15:0] a_sin_ff, a_cos_ff;
   logic signed [39:0] b_lx_ff, b_ly_ff;
   logic signed [55:0] c_xc_ff, c_ys_ff, c_xs_ff, c_yc_ff;
   logic signed [56:0] vx, vy, rx, ry;
   logic signed [25:0] d_dx_ff, d_dy_ff;
   logic signed [26:0] sum_x, sum_y;
   rsp_type            rsp_data_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      div_cnt_in = div_cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      acc_in = acc_ff;
      idx_in = idx_ff;
      total_in = total_ff;
      ca_in = ca_ff;
      sa_in = sa_ff;
      job_pop = 1'b0;
      issue = 1'b0;
      issue_meta = '0;
      rem_shift = {rem_ff, (div_cnt_ff == 6'd0)};
      rem_ge = (rem_shift >= {1'b0, total_ff});
      rem_sub = 7'(rem_shift - {1'b0, total_ff});
      last_vertex = (({1'b0, idx_ff} + 7'd1) == total_ff);
      unique case (state_ff)
         StIdle: begin
            if (job_valid) begin
               if (!job.fits) begin
                  // count-only beat
                  if (adv) begin
                     job_pop = 1'b1;
                     issue = 1'b1;
                     issue_meta.total = job.total;
                     issue_meta.last = 1'b1;
                  end
               end else begin
                  job_pop = 1'b1;
                  total_in = job.total;
                  div_cnt_in = 6'd0;
                  rem_in = 7'd0;
                  quo_in = 32'd0;
                  ca_in = sine_lookup(cfg.rotation + 16'd16384);
                  sa_in = sine_lookup(cfg.rotation);
                  state_in = StDivide;
               end
            end
         end
         StDivide: begin
            rem_in = rem_ge ? rem_sub : rem_shift[6:0];
            quo_in = {quo_ff[30:0], rem_ge};
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'(DivSteps - 1)) begin
               acc_in = 32'd0;
               idx_in = 6'd0;
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (adv) begin
               issue = 1'b1;
               issue_meta.index = idx_ff;
               issue_meta.total = total_ff;
               issue_meta.written = 1'b1;
               issue_meta.last = last_vertex;
               acc_in = acc_ff + quo_ff;
               idx_in = idx_ff + 6'd1;
               if (last_vertex) begin
                  state_in = StIdle;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         div_cnt_ff <= 6'd0;
         rem_ff <= 7'd0;
         quo_ff <= 32'd0;
         acc_ff <= 32'd0;
         idx_ff <= 6'd0;
         total_ff <= 7'd0;
      end else begin
         state_ff <= state_in;
         div_cnt_ff <= div_cnt_in;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         acc_ff <= acc_in;
         idx_ff <= idx_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      ca_ff <= ca_in;
      sa_ff <= sa_in;
   end

   // Rotate and round
   always_comb begin
      vx = 57'(c_xc_ff) - 57'(c_ys_ff);
      vy = 57'(c_xs_ff) + 57'(c_yc_ff);
      // half away from zero: negative values take one less
      rx = vx + (vx[56] ? 57'sd134217727 : 57'sd134217728);
      ry = vy + (vy[56] ? 57'sd134217727 : 57'sd134217728);
      sum_x = 27'(cfg.center_x) + 27'(d_dx_ff);
      sum_y = 27'(cfg.center_y) + 27'(d_dy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= issue;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         rsp_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_meta_ff <= issue_meta;
         a_sin_ff <= sine_lookup(acc_ff[31:16]);
         a_cos_ff <= sine_lookup(acc_ff[31:16] + 16'd16384);

         b_meta_ff <= a_meta_ff;
         b_lx_ff <= $signed({1'b0, cfg.radius_x}) * a_cos_ff;
         b_ly_ff <= $signed({1'b0, cfg.radius_y}) * a_sin_ff;

         c_meta_ff <= b_meta_ff;
         c_xc_ff <= b_lx_ff * ca_ff;
         c_ys_ff <= b_ly_ff * sa_ff;
         c_xs_ff <= b_lx_ff * sa_ff;
         c_yc_ff <= b_ly_ff * ca_ff;

         d_meta_ff <= c_meta_ff;
         d_dx_ff <= rx[53:28];
         d_dy_ff <= ry[53:28];

         rsp_data_ff.vertex_index <= d_meta_ff.index;
         rsp_data_ff.segment_total <= d_meta_ff.total;
         rsp_data_ff.written <= d_meta_ff.written;
         rsp_data_ff.last <= d_meta_ff.last;
         if (d_meta_ff.written) begin
            rsp_data_ff.vertex_x <= sat24(sum_x);
            rsp_data_ff.vertex_y <= sat24(sum_y);
         end else begin
            rsp_data_ff.vertex_x <= 24'sd0;
            rsp_data_ff.vertex_y <= 24'sd0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

// File: rtl/eovg_checker.sv
`include "ellipse_outline_vertex_generator_top_defines.svh"

module eovg_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input eovg_pkg::rsp_type rsp_data
);

   // A stalled beat holds.
   `EOVG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // A count-only beat ends its request and carries no vertex.
   `EOVG_ASSERT_NOW(a_count_only, clock, reset, rsp_valid && !rsp_data.written, rsp_data.last && rsp_data.vertex_x == 24'sd0 && rsp_data.vertex_y == 24'sd0 && rsp_data.vertex_index == 6'd0)

   // The final vertex sits at index N-1.
   `EOVG_ASSERT_NOW(a_last_index, clock, reset, rsp_valid && rsp_data.written && rsp_data.last, (7'(rsp_data.vertex_index) + 7'd1) == rsp_data.segment_total)

   // Beats before the last are vertices below index N-1.
   `EOVG_ASSERT_NOW(a_mid_index, clock, reset, rsp_valid && !rsp_data.last, rsp_data.written && (7'(rsp_data.vertex_index) + 7'd1) < rsp_data.segment_total)

   // Nothing comes out right after reset.
   `EOVG_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid)

endmodule

bind ellipse_outline_vertex_generator_top eovg_checker u_checker (.*);

// File: tb/tb_ellipse_outline_vertex_generator_top.sv
module tb_ellipse_outline_vertex_generator_top;
   import eovg_pkg::*;

   localparam int unsigned SineBits = 10;
   localparam int unsigned QuarterSteps = 1 << (SineBits - 2);
   localparam int unsigned LastRegIndex = (1 << CsrIndexBits) - 1;
   localparam int unsigned SettleCycles = 120;
   localparam int unsigned LongHoldCycles = 400;
   localparam int unsigned RandomPerSetting = 35;
   localparam int unsigned SettingCount = 6;
   localparam longint unsigned CycleLimit = 600000;
   localparam int unsigned DirectedCount = 22;
   localparam int DirSeg[DirectedCount] = '{1, 1, 0, 0, 64, 64, 65, 127, 127, 2, 3,
                                          4, 5, 7, 8, 16, 12, 6, 0, 32, 63, 100};
   localparam int DirRoom[DirectedCount] = '{1, 0, 64, 63, 64, 127, 127, 127, 63, 2, 3,
                                           127, 4, 7, 16, 16, 100, 0, 0, 31, 64, 64};

   class outline_scoreboard;
      cfg_type shape;
      int quarter_wave[QuarterSteps + 1];
      rsp_type expected_vertices[$];
      int mismatches;

      function new();
         longint unsigned x, x2, term;
         longint sum, v;
         shape = '0;
         mismatches = 0;
         for (int unsigned q = 0; q <= QuarterSteps; q++) begin
            x = (TwoPiQ30 * q + (64'd1 << (SineBits - 1))) >> SineBits;
            x2 = (x * x + (64'd1 << 29)) >> 30;
            term = x;
            sum = longint'(x);
            for (int n = 1; n <= 10; n++) begin
               term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  sum = sum - longint'(term);
               end else begin
                  sum = sum + longint'(term);
               end
            end
            v = (sum <= 0) ? 0 : ((sum + 32768) >>> 16);
            quarter_wave[q] = (v > longint'(OneQ14)) ? int'(OneQ14) : int'(v);
         end
      endfunction

      function longint sine_q14(logic [15:0] angle);
         int unsigned k, quad, j;
         longint v;
         k = 32'(angle) >> (16 - SineBits);
         quad = (k >> (SineBits - 2)) & 3;
         j = k & (QuarterSteps - 1);
         v = (quad & 1) ? longint'(quarter_wave[QuarterSteps - j])
                        : longint'(quarter_wave[j]);
         return (quad & 2) ? -v : v;
      endfunction

      function longint cosine_q14(logic [15:0] angle);
         logic [15:0] shifted;
         shifted = angle + 16'd16384;
         return sine_q14(shifted);
      endfunction

      // Q.28 back to Q15.8, ties away from zero
      function longint round_away(longint v);
         if (v >= 0) return (v + 134217728) >>> 28;
         return -((-v + 134217728) >>> 28);
      endfunction

      function logic signed [23:0] clamp24(longint v);
         if (v > 8388607) v = 8388607;
         if (v < -8388608) v = -8388608;
         return v[23:0];
      endfunction

      function void set_register(logic [CsrIndexBits-1:0] idx, logic [CsrDataBits-1:0] data);
         case (idx)
            RegCenterX: shape.center_x = data;
            RegCenterY: shape.center_y = data;
            RegRadiusX: shape.radius_x = data[22:0];
            RegRadiusY: shape.radius_y = data[22:0];
            RegRotation: shape.rotation = data[15:0];
            default: ;
         endcase
      endfunction

      function void note_request(req_type r);
         int unsigned n, room;
         longint ca, sa, lx, ly, rx, ry, cx, cy;
         logic [31:0] step, acc;
         rsp_type v;
         n = 32'(r.segment_request);
         if (n == 0 || n > 32'(MaxSegments)) n = 32'(MaxSegments);
         room = 32'(r.room);
         if (room > 32'(MaxSegments)) room = 32'(MaxSegments);
         v = '0;
         v.segment_total = 7'(n);
         if (room < n) begin
            v.last = 1'b1;
            expected_vertices.push_back(v);
            return;
         end
         step = 32'(64'h1_0000_0000 / n);
         acc = '0;
         ca = cosine_q14(shape.rotation);
         sa = sine_q14(shape.rotation);
         rx = longint'(shape.radius_x);
         ry = longint'(shape.radius_y);
         cx = longint'(shape.center_x);
         cy = longint'(shape.center_y);
         for (int unsigned i = 0; i < n; i++) begin
            lx = rx * cosine_q14(acc[31:16]);
            ly = ry * sine_q14(acc[31:16]);
            v.vertex_x = clamp24(cx + round_away(lx * ca - ly * sa));
            v.vertex_y = clamp24(cy + round_away(lx * sa + ly * ca));
            v.vertex_index = i[5:0];
            v.written = 1'b1;
            v.last = (i + 1 == n);
            expected_vertices.push_back(v);
            acc = acc + step;
         end
      endfunction

      function void compare_field(string name, longint want, longint got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_vertex(rsp_type got);
         rsp_type want;
         if (expected_vertices.size() == 0) begin
            $error("unexpected beat: vertex_index %0d", got.vertex_index);
            mismatches++;
            return;
         end
         want = expected_vertices.pop_front();
         compare_field("vertex_x", want.vertex_x, got.vertex_x);
         compare_field("vertex_y", want.vertex_y, got.vertex_y);
         compare_field("vertex_index", want.vertex_index, got.vertex_index);
         compare_field("segment_total", want.segment_total, got.segment_total);
         compare_field("written", want.written, got.written);
         compare_field("last", want.last, got.last);
      endfunction

      function int outstanding();
         return expected_vertices.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CsrDataBits-1:0] csr_wr_data = '0;

   outline_scoreboard board;
   int unsigned send_idle_pct = 9;
   int unsigned rsp_idle_pct = 45;
   int unsigned holds_asked = 0;
   int unsigned holds_done = 0;
   int unsigned hold_left = 0;
   longint unsigned cycles_run = 0;

   ellipse_outline_vertex_generator_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: check beats, stall at random, honor long hold-off requests.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_vertex(rsp_data);
      if (holds_done != holds_asked) begin
         holds_done = holds_asked;
         hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexBits-1:0] idx,
                                 input logic [CsrDataBits-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      board.set_register(idx, data);
   endtask

   task automatic program_ellipse(input logic [23:0] cx, input logic [23:0] cy,
                                  input logic [23:0] rx, input logic [23:0] ry,
                                  input logic [23:0] rot);
      write_register(RegCenterX, cx);
      write_register(RegCenterY, cy);
      write_register(RegRadiusX, rx);
      write_register(RegRadiusY, ry);
      write_register(RegRotation, rot);
      // unmapped index: must leave the shape alone
      write_register(CsrIndexBits'($urandom_range(int'(RegRotation) + 1, LastRegIndex)),
                     CsrDataBits'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_type random_request();
      req_type r;
      int unsigned roll, n, pick;
      roll = $urandom_range(99);
      pick = $urandom_range(9);
      if (pick == 0) begin
         r.segment_request = 7'd0;
      end else if (pick == 1) begin
         r.segment_request = 7'($urandom_range(65, 127));
      end else begin
         r.segment_request = 7'($urandom_range(1, 64));
      end
      n = 32'(r.segment_request);
      if (n == 0 || n > 32'(MaxSegments)) n = 32'(MaxSegments);
      if (roll < 72) begin
         r.room = 7'($urandom_range(n, 127));
      end else if (roll < 90) begin
         r.room = 7'($urandom_range(0, n - 1));
      end else begin
         r.segment_request = 7'($urandom);
         r.room = 7'($urandom);
      end
      return r;
   endfunction

   initial begin
      req_type r;
      logic [23:0] cx, cy, rx, ry, rot;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_ellipse(24'h00C800, 24'hFF6A00, 24'h006400, 24'h003200, 24'h002000);
      for (int d = 0; d < DirectedCount; d++) begin
         r.segment_request = 7'(DirSeg[d]);
         r.room = 7'(DirRoom[d]);
         send_request(r);
      end

      for (int p = 0; p < SettingCount; p++) begin
         case (p)
            0: begin
               cx = 24'($urandom_range(0, 24'h1FFFFF) - 24'h100000);
               cy = 24'($urandom_range(0, 24'h1FFFFF) - 24'h100000);
               rx = 24'($urandom_range(0, 24'h03FFFF));
               ry = 24'($urandom_range(0, 24'h03FFFF));
               rot = 24'($urandom);
            end
            1: begin
               // saturate both ways, high radius bit and rotation top bits masked
               cx = 24'h7FFFFF;
               cy = 24'h800000;
               rx = 24'hFFFFFF;
               ry = 24'h7FFFFF;
               rot = 24'hFFFFFF;
            end
            2: begin
               cx = '0;
               cy = '0;
               rx = '0;
               ry = '0;
               rot = '0;
            end
            3: begin
               cx = 24'($urandom);
               cy = 24'($urandom);
               rx = 24'($urandom);
               ry = 24'($urandom);
               rot = 24'($urandom);
            end
            4: begin
               cx = 24'h800000;
               cy = 24'h7FFFFF;
               rx = 24'($urandom_range(0, 24'h7FFFFF));
               ry = 24'($urandom_range(0, 24'h7FFFFF));
               rot = 24'h004000;
            end
            default: begin
               cx = 24'($urandom_range(0, 24'h0FFFFF) - 24'h080000);
               cy = 24'($urandom_range(0, 24'h0FFFFF) - 24'h080000);
               rx = 24'($urandom_range(0, 24'h00FFFF));
               ry = 24'($urandom_range(0, 24'h00FFFF));
               rot = 24'($urandom);
            end
         endcase
         wait_idle();
         program_ellipse(cx, cy, rx, ry, rot);
         if (p < 2) begin
            send_idle_pct = 9;
            rsp_idle_pct = 45;
         end else if (p < 4) begin
            send_idle_pct = 45;
            rsp_idle_pct = 9;
         end else begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         for (int k = 0; k < RandomPerSetting; k++) begin
            // back up the block behind a long receiver hold while requests keep coming
            if (p == 0 && k == 10) holds_asked++;
            if (p == 2 && k == 15) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (board.outstanding() != 0) @(posedge clock);
            end
            send_request(random_request());
         end
      end

      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/eovg_pkg.sv
rtl/eovg_front.sv
rtl/eovg_queue.sv
rtl/eovg_back.sv
rtl/ellipse_outline_vertex_generator_top.sv
rtl/eovg_checker.sv
tb/tb_ellipse_outline_vertex_generator_top.sv
